// ===== rtl/core/lfs_pkg.sv =====
// lfs_pkg: shared constants, types and tables for the line-follow steering block
// holds stage counts, register indexes, the arctangent table and the cordic state type
// no dependencies
package lfs_pkg;

    // number of cordic vectoring steps (8 to 24)
    localparam int CORDIC_STEPS = 16;

    // iterative unit depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    // stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // pi in q.16 radians
    localparam logic signed [20:0] PI_Q16 = 21'sd205887;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_GOAL_X   = 3'd2,
        REG_GOAL_Y   = 3'd3,
        REG_GAIN     = 3'd4,
        REG_SPEED    = 3'd5,
        REG_MAX_TURN = 3'd6
    } t_reg_idx;

    // cordic vector and angle accumulator
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [20:0] z;
    } t_ang;

    // arctangent of 2^-i in q.16 radians
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/line_follow_steering_top.sv =====
// line_follow_steering_top: cross-track steering controller, fully pipelined
// square root, divider, shift normaliser and cordic are unrolled into register stages
// depends on lfs_pkg
//
// channel  | direction | beat contents
// ---------+-----------+------------------------------------------------------------
// s_*      | in        | tdata: robot_x [31:0], robot_y [63:32]
// m_*      | out       | tdata: linear_speed [15:0], turn_rate [31:16];
//          |           | tuser: clamped [0], degenerate [1]
// cfg_*    | in        | index selects register, data holds its value (low bits used)
//
// a pose is taken every cycle while the skid register is empty; its command passes through
// the 32-stage square root followed by the 32-stage divider
// reset (synchronous, active low) clears all valid bits and loads the default registers
// the pipeline moves as one; it halts only while the skid register holds a beat, so the
// input keeps flowing while a single finished beat waits at the output
module line_follow_steering_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lfs_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // robot_x, robot_y
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [lfs_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // linear_speed, turn_rate
    output logic [lfs_pkg::OUT_TUSER_W-1:0]    o_m_tuser,   // clamped, degenerate
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic signed [32:0] LIM30_33 = 33'sd1073741824;
    localparam logic signed [63:0] LIM30_64 = 64'sd1073741824;
    localparam int NSQ = lfs_pkg::SQRT_STAGES;
    localparam int NDV = lfs_pkg::DIV_STAGES;
    localparam int NCS = lfs_pkg::CORDIC_STEPS;

    // configuration registers
    logic signed [31:0] r_start_x, r_start_y, r_goal_x, r_goal_y;
    logic        [15:0] r_gain;
    logic        [15:0] r_speed;
    logic        [14:0] r_max_turn;

    logic en;
    logic r_skid_valid;

    assign en          = !r_skid_valid;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_goal_x   <= 32'sd65536;
            r_goal_y   <= '0;
            r_gain     <= 16'd2560;
            r_speed    <= 16'd2048;
            r_max_turn <= 15'd2048;
        end else if (i_cfg_valid) begin
            case (lfs_pkg::t_reg_idx'(i_cfg_index))
                lfs_pkg::REG_START_X:  r_start_x  <= i_cfg_data;
                lfs_pkg::REG_START_Y:  r_start_y  <= i_cfg_data;
                lfs_pkg::REG_GOAL_X:   r_goal_x   <= i_cfg_data;
                lfs_pkg::REG_GOAL_Y:   r_goal_y   <= i_cfg_data;
                lfs_pkg::REG_GAIN:     r_gain     <= i_cfg_data[15:0];
                lfs_pkg::REG_SPEED:    r_speed    <= i_cfg_data[15:0];
                lfs_pkg::REG_MAX_TURN: r_max_turn <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // helpers
    function automatic logic in30_33(input logic signed [32:0] v);
        return (v >= -LIM30_33) && (v <= LIM30_33);
    endfunction

    function automatic logic in30_64(input logic signed [63:0] v);
        return (v >= -LIM30_64) && (v <= LIM30_64);
    endfunction

    function automatic logic [1:0] fit_s(input logic signed [32:0] a, input logic signed [32:0] b,
                                         input logic signed [32:0] c, input logic signed [32:0] d);
        logic [1:0] s;
        if (in30_33(a) && in30_33(b) && in30_33(c) && in30_33(d))
            s = 2'd0;
        else if (in30_33(a >>> 1) && in30_33(b >>> 1) && in30_33(c >>> 1) && in30_33(d >>> 1))
            s = 2'd1;
        else
            s = 2'd2;
        return s;
    endfunction

    function automatic logic signed [31:0] shr(input logic signed [32:0] v, input logic [1:0] s);
        logic signed [32:0] t;
        t = v >>> s;
        return t[31:0];
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return a * b;
    endfunction

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    // stage 1: coordinate differences
    logic               r1_v;
    logic signed [32:0] r1_a1, r1_a2, r1_b1, r1_b2, r1_c1, r1_c2, r1_e1, r1_e2;
    logic signed [31:0] w_rx, w_ry;

    assign w_rx = i_s_tdata[31:0];
    assign w_ry = i_s_tdata[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= i_s_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a1 <= sx33(r_goal_x) - sx33(r_start_x);
            r1_a2 <= sx33(r_goal_y) - sx33(r_start_y);
            r1_b1 <= sx33(w_rx) - sx33(r_start_x);
            r1_b2 <= sx33(w_ry) - sx33(r_start_y);
            r1_c1 <= sx33(r_start_x) - sx33(r_goal_x);
            r1_c2 <= sx33(r_start_y) - sx33(r_goal_y);
            r1_e1 <= sx33(w_rx) - sx33(r_goal_x);
            r1_e2 <= sx33(w_ry) - sx33(r_goal_y);
        end
    end

    // stage 2: range fitting shift for both vector pairs
    logic               r2_v, r2_degen;
    logic [1:0]         r2_s;
    logic signed [31:0] r2_a1, r2_a2, r2_b1, r2_b2, r2_c1, r2_c2, r2_e1, r2_e2;
    logic [1:0]         n_s1, n_s2;

    assign n_s1 = fit_s(r1_a1, r1_a2, r1_b1, r1_b2);
    assign n_s2 = fit_s(r1_c1, r1_c2, r1_e1, r1_e2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_s     <= n_s1;
            r2_a1    <= shr(r1_a1, n_s1);
            r2_a2    <= shr(r1_a2, n_s1);
            r2_b1    <= shr(r1_b1, n_s1);
            r2_b2    <= shr(r1_b2, n_s1);
            r2_c1    <= shr(r1_c1, n_s2);
            r2_c2    <= shr(r1_c2, n_s2);
            r2_e1    <= shr(r1_e1, n_s2);
            r2_e2    <= shr(r1_e2, n_s2);
            r2_degen <= ((r1_c1 == '0) && (r1_c2 == '0)) || ((r1_e1 == '0) && (r1_e2 == '0));
        end
    end

    // stage 3: products
    logic               r3_v, r3_degen;
    logic [1:0]         r3_s;
    logic signed [63:0] r3_aa1, r3_aa2, r3_ab21, r3_ab12;
    logic signed [63:0] r3_ce21, r3_ce12, r3_ce11, r3_ce22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_s     <= r2_s;
            r3_degen <= r2_degen;
            r3_aa1   <= smul(r2_a1, r2_a1);
            r3_aa2   <= smul(r2_a2, r2_a2);
            r3_ab21  <= smul(r2_a1, r2_b2);
            r3_ab12  <= smul(r2_a2, r2_b1);
            r3_ce21  <= smul(r2_c1, r2_e2);
            r3_ce12  <= smul(r2_c2, r2_e1);
            r3_ce11  <= smul(r2_c1, r2_e1);
            r3_ce22  <= smul(r2_c2, r2_e2);
        end
    end

    // square root and normaliser stages; index 0 is stage 4
    logic               rb_v     [0:NSQ];
    logic [63:0]        rb_sv    [0:NSQ];
    logic [63:0]        rb_sr    [0:NSQ];
    logic signed [63:0] rb_crd   [0:NSQ];
    logic signed [63:0] rb_cr    [0:NSQ];
    logic signed [63:0] rb_dot   [0:NSQ];
    logic [1:0]         rb_s     [0:NSQ];
    logic               rb_degen [0:NSQ];
    logic               rb_zero  [0:NSQ];
    logic signed [63:0] n_cra, n_dot;

    assign n_cra = r3_ce21 - r3_ce12;
    assign n_dot = r3_ce11 + r3_ce22;

    // stage 4: sums of products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v[0] <= 1'b0;
        else if (en)  rb_v[0] <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_sv[0]    <= r3_aa1 + r3_aa2;
            rb_sr[0]    <= '0;
            rb_crd[0]   <= r3_ab21 - r3_ab12;
            rb_cr[0]    <= n_cra;
            rb_dot[0]   <= n_dot;
            rb_s[0]     <= r3_s;
            rb_degen[0] <= r3_degen;
            rb_zero[0]  <= (n_cra == '0) && (n_dot == '0);
        end
    end

    // one root bit and at most one normalising shift per stage
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_trial;
        logic        w_fit;

        assign w_trial = rb_sr[k] + BIT;
        assign w_fit   = in30_64(rb_cr[k]) && in30_64(rb_dot[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rb_v[k+1] <= 1'b0;
            else if (en)  rb_v[k+1] <= rb_v[k];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rb_sv[k] >= w_trial) begin
                    rb_sv[k+1] <= rb_sv[k] - w_trial;
                    rb_sr[k+1] <= (rb_sr[k] >> 1) + BIT;
                end else begin
                    rb_sv[k+1] <= rb_sv[k];
                    rb_sr[k+1] <= rb_sr[k] >> 1;
                end
                rb_cr[k+1]    <= w_fit ? rb_cr[k]  : (rb_cr[k]  >>> 1);
                rb_dot[k+1]   <= w_fit ? rb_dot[k] : (rb_dot[k] >>> 1);
                rb_crd[k+1]   <= rb_crd[k];
                rb_s[k+1]     <= rb_s[k];
                rb_degen[k+1] <= rb_degen[k];
                rb_zero[k+1]  <= rb_zero[k];
            end
        end
    end

    // divider and cordic stages; index 0 is the preparation stage
    logic                rc_v     [0:NDV];
    logic [63:0]         rc_rem   [0:NDV];
    logic [31:0]         rc_len   [0:NDV];
    logic [31:0]         rc_q     [0:NDV];
    logic                rc_neg   [0:NDV];
    logic [1:0]          rc_s     [0:NDV];
    logic                rc_degen [0:NDV];
    logic                rc_zero  [0:NDV];
    lfs_pkg::t_ang       rc_ang   [0:NDV];
    logic signed [63:0]  w_crd_last;
    lfs_pkg::t_ang       n_ang0;

    assign w_crd_last = rb_crd[NSQ];

    // turn by pi when the vector points into the left half plane
    always_comb begin
        n_ang0.x = rb_dot[NSQ][33:0];
        n_ang0.y = rb_cr[NSQ][33:0];
        n_ang0.z = '0;
        if (rb_dot[NSQ] < 0) begin
            n_ang0.x = -rb_dot[NSQ][33:0];
            n_ang0.y = -rb_cr[NSQ][33:0];
            n_ang0.z = (rb_cr[NSQ] >= 0) ? lfs_pkg::PI_Q16 : -lfs_pkg::PI_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_v[0] <= 1'b0;
        else if (en)  rc_v[0] <= rb_v[NSQ];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_rem[0]   <= (w_crd_last < 0) ? 64'(-w_crd_last) : 64'(w_crd_last);
            rc_len[0]   <= rb_sr[NSQ][31:0];
            rc_q[0]     <= '0;
            rc_neg[0]   <= w_crd_last < 0;
            rc_s[0]     <= rb_s[NSQ];
            rc_degen[0] <= rb_degen[NSQ];
            rc_zero[0]  <= rb_zero[NSQ];
            rc_ang[0]   <= n_ang0;
        end
    end

    // one quotient bit per stage; cordic steps ride along, then rounding, then hold
    for (genvar j = 0; j < NDV; j++) begin : g_div
        localparam int QB = NDV - 1 - j;
        logic [63:0]   w_sub;
        lfs_pkg::t_ang w_nxt;
        logic signed [33:0] w_xs, w_ys;
        logic signed [20:0] w_tab;

        assign w_sub = {32'd0, rc_len[j]} << QB;
        assign w_xs  = rc_ang[j].x >>> j;
        assign w_ys  = rc_ang[j].y >>> j;
        assign w_tab = {5'd0, lfs_pkg::atan_q16(5'(j))};

        always_comb begin
            w_nxt = rc_ang[j];
            if (j < NCS) begin
                if (rc_ang[j].y > 0) begin
                    w_nxt.x = rc_ang[j].x + w_ys;
                    w_nxt.y = rc_ang[j].y - w_xs;
                    w_nxt.z = rc_ang[j].z + w_tab;
                end else begin
                    w_nxt.x = rc_ang[j].x - w_ys;
                    w_nxt.y = rc_ang[j].y + w_xs;
                    w_nxt.z = rc_ang[j].z - w_tab;
                end
            end else if (j == NCS) begin
                w_nxt.z = (rc_ang[j].z + 21'sd8) >>> 4;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rc_v[j+1] <= 1'b0;
            else if (en)  rc_v[j+1] <= rc_v[j];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rc_rem[j] >= w_sub) begin
                    rc_rem[j+1] <= rc_rem[j] - w_sub;
                    rc_q[j+1]   <= rc_q[j] | (32'd1 << QB);
                end else begin
                    rc_rem[j+1] <= rc_rem[j];
                    rc_q[j+1]   <= rc_q[j];
                end
                rc_len[j+1]   <= rc_len[j];
                rc_neg[j+1]   <= rc_neg[j];
                rc_s[j+1]     <= rc_s[j];
                rc_degen[j+1] <= rc_degen[j];
                rc_zero[j+1]  <= rc_zero[j];
                rc_ang[j+1]   <= w_nxt;
            end
        end
    end

    // d1: signed, rescaled distance and final angle term
    logic               rd1_v, rd1_degen;
    logic signed [35:0] rd1_dist;
    logic signed [16:0] rd1_ang;
    logic signed [35:0] n_q36;

    assign n_q36 = {4'd0, rc_q[NDV]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd1_v <= 1'b0;
        else if (en)  rd1_v <= rc_v[NDV];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (rc_len[NDV] == '0)
                rd1_dist <= '0;
            else
                rd1_dist <= (rc_neg[NDV] ? -n_q36 : n_q36) <<< rc_s[NDV];
            rd1_ang   <= (rc_degen[NDV] || rc_zero[NDV]) ? '0 : rc_ang[NDV].z[16:0];
            rd1_degen <= rc_degen[NDV];
        end
    end

    // d2: gain product
    logic               rd2_v, rd2_degen;
    logic signed [52:0] rd2_prod;
    logic signed [16:0] rd2_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd2_v <= 1'b0;
        else if (en)  rd2_v <= rd1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd2_prod  <= 53'(rd1_dist) * 53'($signed({1'b0, r_gain}));
            rd2_ang   <= rd1_ang;
            rd2_degen <= rd1_degen;
        end
    end

    // d3: sum and clamp
    logic               rd3_v;
    logic [15:0]        rd3_turn;
    logic               rd3_clamped, rd3_degen;
    logic [15:0]        rd3_speed;
    logic signed [52:0] n_scaled;
    logic signed [41:0] n_sum, n_mx;

    assign n_scaled = rd2_prod >>> 12;
    assign n_sum    = n_scaled[41:0] + 42'(rd2_ang);
    assign n_mx     = {27'd0, r_max_turn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd3_v <= 1'b0;
        else if (en)  rd3_v <= rd2_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd3_degen <= rd2_degen;
            rd3_speed <= r_speed;
            if (n_sum > n_mx) begin
                rd3_turn    <= n_mx[15:0];
                rd3_clamped <= 1'b1;
            end else if (n_sum < -n_mx) begin
                rd3_turn    <= -n_mx[15:0];
                rd3_clamped <= 1'b1;
            end else begin
                rd3_turn    <= n_sum[15:0];
                rd3_clamped <= 1'b0;
            end
        end
    end

    // output register with skid stage
    logic                              r_out_valid;
    logic [lfs_pkg::OUT_TDATA_W-1:0]   r_out_data, r_skid_data;
    logic [lfs_pkg::OUT_TUSER_W-1:0]   r_out_user, r_skid_user;
    logic                              w_free, w_inc;

    assign w_free = !r_out_valid || i_m_tready;
    assign w_inc  = rd3_v && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            r_out_valid  <= r_skid_valid || w_inc;
            r_skid_valid <= 1'b0;
        end else if (w_inc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= {rd3_turn, rd3_speed};
                r_out_user <= {rd3_degen, rd3_clamped};
            end
        end else if (w_inc) begin
            r_skid_data <= {rd3_turn, rd3_speed};
            r_skid_user <= {rd3_degen, rd3_clamped};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== rtl/core/lfs_checker.sv =====
// lfs_checker: port-level checks on the line-follow steering top level
// bound to line_follow_steering_top; depends on lfs_pkg
module lfs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [lfs_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic [lfs_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    // the skid stage only fills behind a waiting output beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // reset empties the output and the skid stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output not empty after reset");

endmodule

bind line_follow_steering_top lfs_checker u_lfs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
